@@ hw/rtl/skvt_pkg.sv @@
// Shared types, sizes and command codes for the sorted key/datum table.
// Used by skvt_cell and sorted_key_value_table; depends on nothing else.

package skvt_pkg;

    // Table size and stored datum width.
    localparam int CAPACITY    = 16;
    localparam int DATUM_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Field widths of the stream words.
    localparam int KEY_W    = 32;
    localparam int DIN_W    = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int STAT_W   = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;

    typedef logic [DATUM_WIDTH-1:0] t_datum;

    // Command codes; the one code left over is a no-op.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_FETCH  = 3'd3,
        CMD_FIRST  = 3'd4,
        CMD_STEP   = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_cmd;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // One stored entry.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        t_datum                  datum;
    } t_entry;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic                    update;
        logic                    insert_new;
        logic                    remove_hit;
        logic signed [KEY_W-1:0] key;
        t_datum                  datum;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/sorted_key_value_table.sv @@
// Top level of the sorted key/datum table: a row of cells plus count and cursor.
// Depends on skvt_pkg and skvt_cell.

// The table holds up to 16 signed-key entries in ascending order in a row of
// cells that all compare against the command key at once and shift sideways
// for insert and remove. Each command runs in two steps: in the first the cells
// update and the count and cursor settle, in the second the entry under the
// cursor is read from the row into the output register. A new word is taken
// only after the previous result is in the output register; a stalled output
// holds the second step until its word is taken.

module sorted_key_value_table
    import skvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // command [2:0], key [34:3], datum [66:35], position [70:67], zero fill [71]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // status [1:0], was_update [2], cursor_valid [3], key_out [35:4],
    // datum_out [67:36], entry_count [72:68], zero fill [79:73]
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    // Input word fields.
    t_cmd                    w_cmd;
    logic signed [KEY_W-1:0] w_key;
    t_datum                  w_datum;
    logic [POS_W-1:0]        w_pos;
    logic                    w_accept;

    assign w_cmd    = t_cmd'(i_s_tdata[CMD_W-1:0]);
    assign w_key    = i_s_tdata[CMD_W+KEY_W-1:CMD_W];
    assign w_datum  = i_s_tdata[CMD_W+KEY_W+DATUM_WIDTH-1:CMD_W+KEY_W];
    assign w_pos    = i_s_tdata[CMD_W+KEY_W+DIN_W+POS_W-1:CMD_W+KEY_W+DIN_W];

    // Control and state registers.
    logic               r_busy;
    logic               r_out_valid;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [IDX_W-1:0]   r_cur_pos, n_cur_pos;
    logic               r_cur_on,  n_cur_on;
    t_status            r_status,  n_status;
    logic               r_upd,     n_upd;
    logic               r_removed, n_removed;
    logic [KEY_W-1:0]   r_rm_key;

    // Output payload registers.
    t_status            r_o_status;
    logic               r_o_upd;
    logic               r_o_cur;
    logic [KEY_W-1:0]   r_o_key;
    logic [DIN_W-1:0]   r_o_datum;
    logic [CNT_W-1:0]   r_o_count;

    logic               w_read;
    assign o_s_tready = !r_busy;
    assign w_accept   = i_s_tvalid && !r_busy;
    assign w_read     = r_busy && (!r_out_valid || i_m_tready);

    // Cell row.
    t_cell_ctrl            w_ctrl;
    t_entry                w_entry [CAPACITY];
    logic [CAPACITY-1:0]   w_lt;
    logic [CAPACITY-1:0]   w_eq;
    logic                  w_hit;
    logic                  w_full;
    logic [IDX_W-1:0]      w_eq_idx;

    assign w_hit  = |w_eq;
    assign w_full = (r_count == CNT_W'(CAPACITY));

    assign w_ctrl.key        = w_key;
    assign w_ctrl.datum      = w_datum;
    assign w_ctrl.update     = w_accept && (w_cmd == CMD_INSERT) && w_hit;
    assign w_ctrl.insert_new = w_accept && (w_cmd == CMD_INSERT) && !w_hit && !w_full;
    assign w_ctrl.remove_hit = w_accept && (w_cmd == CMD_REMOVE) && w_hit;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_lt;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_lt = 1'b1;
        end else begin : g_mid
            assign w_left    = w_entry[g-1];
            assign w_left_lt = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        skvt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_occupied (CNT_W'(g) < r_count),
            .i_left_lt  (w_left_lt),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g]),
            .o_entry    (w_entry[g])
        );
    end

    // Index of the matching cell; at most one cell matches.
    always_comb begin
        w_eq_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_eq[i]) begin
                w_eq_idx = w_eq_idx | IDX_W'(i);
            end
        end
    end

    // Next count, cursor and status for the accepted command.
    logic [CNT_W-1:0] w_pos_ext;
    logic [CNT_W-1:0] w_step_ext;
    logic             w_on;

    assign w_pos_ext  = CNT_W'(w_pos);
    assign w_step_ext = CNT_W'(r_cur_pos) + CNT_W'(1);

    always_comb begin
        n_count   = r_count;
        n_cur_pos = r_cur_pos;
        w_on      = r_cur_on;
        n_status  = ST_OK;
        n_upd     = 1'b0;
        n_removed = 1'b0;
        unique case (w_cmd)
            CMD_INSERT: begin
                w_on = 1'b0;
                if (w_hit) begin
                    n_upd = 1'b1;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                w_on = 1'b0;
                if (w_hit) begin
                    n_removed = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_FIND: begin
                w_on = w_hit;
                if (w_hit) begin
                    n_cur_pos = w_eq_idx;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_FETCH: begin
                if (w_pos_ext < r_count) begin
                    w_on      = 1'b1;
                    n_cur_pos = IDX_W'(w_pos);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            CMD_FIRST: begin
                w_on      = (r_count != '0);
                n_cur_pos = '0;
            end
            CMD_STEP: begin
                if (r_cur_on && (w_step_ext < r_count)) begin
                    n_cur_pos = IDX_W'(w_step_ext);
                end else begin
                    w_on = 1'b0;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
                w_on    = 1'b0;
            end
            default: begin
            end
        endcase
        // A cursor past the last entry goes off.
        n_cur_on = w_on && (CNT_W'(n_cur_pos) < n_count);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_cur_pos   <= '0;
            r_cur_on    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy    <= 1'b1;
                r_count   <= n_count;
                r_cur_pos <= n_cur_pos;
                r_cur_on  <= n_cur_on;
            end else if (w_read) begin
                r_busy <= 1'b0;
            end
            if (w_read) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-command result bits held between the two steps.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_upd     <= n_upd;
            r_removed <= n_removed;
            r_rm_key  <= w_key;
        end
    end

    // Second step: read the entry under the cursor into the output word.
    t_entry w_cur_entry;
    assign w_cur_entry = w_entry[r_cur_pos];

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_o_status <= r_status;
            r_o_upd    <= r_upd;
            r_o_cur    <= r_cur_on;
            r_o_count  <= r_count;
            if (r_cur_on) begin
                r_o_key   <= w_cur_entry.key;
                r_o_datum <= DIN_W'(w_cur_entry.datum);
            end else begin
                r_o_key   <= r_removed ? r_rm_key : '0;
                r_o_datum <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_o_count, r_o_datum, r_o_key, r_o_cur, r_o_upd, r_o_status};

    // The count never goes beyond the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A cursor that is on always points inside the table.
    a_cursor_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_on |-> (CNT_W'(r_cur_pos) < r_count))
        else $error("cursor past last entry");

    // An accepted word holds the input side until its result is written out.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && !o_s_tready))
        else $error("input taken while a command is in flight");

    // With the cursor off, the reported datum is zero.
    a_datum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_cur) |-> (r_o_datum == '0))
        else $error("datum reported with cursor off");

endmodule

@@ hw/rtl/skvt_cell.sv @@
// One cell of the sorted table: holds one entry and compares it with the command key.
// Depends on skvt_pkg for the entry and control types.

module skvt_cell
    import skvt_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  logic       i_left_lt,
    input  t_entry     i_left,
    input  t_entry     i_right,
    output logic       o_lt,
    output logic       o_eq,
    output t_entry     o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // Compare the held key with the command key.
    assign o_lt    = i_occupied && ($signed(r_entry.key) < $signed(i_ctrl.key));
    assign o_eq    = i_occupied && (r_entry.key == i_ctrl.key);
    assign o_entry = r_entry;

    // Insert opens a slot at the first cell not below the key; remove closes it.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.update && o_eq) begin
            n_entry.datum = i_ctrl.datum;
        end else if (i_ctrl.insert_new && !o_lt) begin
            if (i_left_lt) begin
                n_entry.key   = i_ctrl.key;
                n_entry.datum = i_ctrl.datum;
            end else begin
                n_entry = i_left;
            end
        end else if (i_ctrl.remove_hit && !o_lt) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
